>>> sv/pfv_pkg.sv
// Shared types, constants and register codes for the pulse frequency verifier.
package pfv_pkg;

    // Sizes and default values
    localparam int SLOTS_DEF   = 10;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    localparam logic [7:0]  ALPHA_RST     = 8'd243;
    localparam logic [11:0] THRESHOLD_RST = 12'd500;
    localparam logic [7:0]  MIN_CNT_RST   = 8'd5;
    localparam logic [31:0] MIN_PERIOD_RST = 32'd900;
    localparam logic [31:0] MAX_PERIOD_RST = 32'd1100;
    localparam logic [31:0] WINDOW_RST    = 32'd2000000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA      = 3'd0,
        CFG_THRESHOLD  = 3'd1,
        CFG_MIN_COUNT  = 3'd2,
        CFG_MIN_PERIOD = 3'd3,
        CFG_MAX_PERIOD = 3'd4,
        CFG_WINDOW     = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0]  alpha;
        logic [11:0] threshold;
        logic [7:0]  min_count;
        logic [31:0] min_period;
        logic [31:0] max_period;
        logic [31:0] window;
    } t_cfg;

    // Item class decided by the front end
    typedef enum logic [0:0] {
        CMD_SAMPLE = 1'b0,
        CMD_START  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [11:0] sample;
        logic [31:0] time_us;
    } t_item;

    typedef struct packed {
        logic        busy_res;
        logic        done_res;
        logic        verified;
        logic        pulse_edge;
        logic [7:0]  pulse_total;
        logic [14:0] filtered_level;
        logic        sunlight_flag;
    } t_res;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_EDGE,
        ST_SCAN,
        ST_MUL,
        ST_DECIDE,
        ST_OUT
    } t_state;

endpackage

>>> sv/pfv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/pfv_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module pfv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  logic           i_func,
    input  logic [11:0]    i_sample,
    input  logic [31:0]    i_time_us,
    output logic           o_item_vld,
    output pfv_pkg::t_item o_item,
    input  logic           i_pop
);
    import pfv_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_item           r_q [QUEUE_DEPTH];
    logic [PW-1:0]   r_wptr;
    logic [PW-1:0]   r_rptr;
    logic [CW-1:0]   r_cnt;
    logic            w_full;
    logic            w_push;
    t_item           w_item;

    assign w_full     = (r_cnt == CW'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !w_full;
    assign o_in_stall = w_full;
    assign o_item_vld = (r_cnt != '0);
    assign o_item     = r_q[r_rptr];

    // Classify the incoming beat
    always_comb begin
        w_item.cmd     = i_func ? CMD_START : CMD_SAMPLE;
        w_item.sample  = i_sample;
        w_item.time_us = i_time_us;
    end

    // Store the beat in the queue
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= w_item;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({w_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

>>> sv/pfv_back.sv
// Back end: filter, edge detection, interval ring, period check and result register.
module pfv_back #(
    parameter int SLOTS = pfv_pkg::SLOTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  pfv_pkg::t_cfg  i_cfg,
    input  logic           i_item_vld,
    input  pfv_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output pfv_pkg::t_res  o_res
);
    import pfv_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);
    localparam int SW = 32 + NW;

    t_state r_state, n_state;

    // Latched item
    t_cmd         r_cmd;
    logic [11:0]  r_x;
    logic [31:0]  r_t;

    // Filter and pulse history
    logic signed [15:0] r_fo;
    logic [14:0]  r_fo_mag;
    logic [11:0]  r_prev;
    logic         r_seen;
    logic         r_lvl;
    logic         r_have;
    logic [31:0]  r_last;
    logic [IW-1:0] r_ptr;
    logic [SLOTS-1:0] r_slot_vld;
    logic [7:0]   r_pc;
    logic [31:0]  r_start;
    logic         r_busy, r_done, r_pass;
    logic         r_edge;
    logic signed [26:0] r_prod;

    // Scan of the interval ring
    logic [NW-1:0] r_idx;
    logic [NW-1:0] r_lim;
    logic          r_pend;
    logic          r_rd_vld;
    logic [SW-1:0] r_sum;
    logic [NW-1:0] r_n;
    logic [SW-1:0] r_lo, r_hi;
    logic          r_chk;

    // Result register
    logic          r_out_vld;
    t_res          r_res;

    // Combinational helpers
    logic signed [15:0] w_fo_eff;
    logic [11:0]   w_prev_eff;
    logic signed [17:0] w_s;
    logic signed [26:0] w_prod;
    logic [26:0]   w_abs;
    logic [18:0]   w_m;
    logic signed [15:0] w_fo_new;
    logic [14:0]   w_mag;
    logic          w_high;
    logic          w_edge;
    logic          w_rec;
    logic [7:0]    w_pc_next;
    logic [7:0]    w_pcm1;
    logic [NW-1:0] w_lim;
    logic          w_go_scan;
    logic          w_issue;
    logic [31:0]   w_rdata;
    logic          w_ok;
    logic [31:0]   w_elapsed;
    logic          w_out_free;
    logic          w_ram_we;
    logic [31:0]   w_wdata;

    // Filter input and product
    always_comb begin
        w_prev_eff = r_seen ? r_prev : r_x;
        w_fo_eff   = r_seen ? r_fo : $signed({4'b0, r_x});
        w_s        = 18'(w_fo_eff) + $signed({6'b0, r_x}) - $signed({6'b0, w_prev_eff});
        w_prod     = $signed({1'b0, i_cfg.alpha}) * w_s;
    end

    // Scale with truncation toward zero, saturate, find the level and edge
    always_comb begin
        w_abs = r_prod[26] ? (~r_prod + 27'd1) : r_prod;
        w_m   = w_abs[26:8];
        if (r_prod[26]) begin
            w_fo_new = (w_m > 19'd32768) ? 16'sh8000 : $signed(~w_m[15:0] + 16'd1);
        end else begin
            w_fo_new = (w_m > 19'd32767) ? 16'sh7fff : $signed(w_m[15:0]);
        end
        w_mag     = (w_m > 19'd32767) ? 15'h7fff : w_m[14:0];
        w_high    = (w_mag > {3'b0, i_cfg.threshold});
        w_edge    = w_high && !r_lvl;
        w_rec     = w_edge && r_have;
        w_pc_next = (w_rec && r_pc != 8'hff) ? r_pc + 8'd1 : r_pc;
        w_pcm1    = w_pc_next - 8'd1;
        w_lim     = ({1'b0, w_pcm1} > 9'(SLOTS)) ? NW'(SLOTS) : NW'(w_pcm1);
        w_go_scan = (w_pc_next >= i_cfg.min_count) && (w_pc_next >= 8'd2);
        w_wdata   = r_t - r_last;
    end

    assign w_ram_we   = (r_state == ST_EDGE) && w_rec;
    assign w_issue    = (r_idx != r_lim);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_elapsed  = r_t - r_start;
    assign w_ok       = r_chk && (r_n != '0) && (r_sum >= r_lo) && (r_sum <= r_hi);

    pfv_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_ptr),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_rdata)
    );

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and queue pop
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_vld) begin
                    o_pop   = 1'b1;
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                unique case (r_cmd)
                    CMD_START:  n_state = ST_OUT;
                    CMD_SAMPLE: n_state = r_busy ? ST_EDGE : ST_OUT;
                    default:    n_state = ST_OUT;
                endcase
            end
            ST_EDGE: begin
                n_state = w_go_scan ? ST_SCAN : ST_DECIDE;
            end
            ST_SCAN: begin
                if (!w_issue && !r_pend) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:    n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_OUT;
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_item_vld) begin
            r_cmd <= i_item.cmd;
            r_x   <= i_item.sample;
            r_t   <= i_item.time_us;
        end
        if (r_state == ST_FILT) begin
            r_prod <= w_prod;
        end
        if (r_state == ST_EDGE) begin
            r_idx  <= '0;
            r_lim  <= w_lim;
            r_sum  <= '0;
            r_n    <= '0;
        end
        if (r_state == ST_SCAN) begin
            if (w_issue) begin
                r_idx <= r_idx + 1'b1;
            end
            if (r_pend && r_rd_vld && w_rdata != '0) begin
                r_sum <= r_sum + SW'(w_rdata);
                r_n   <= r_n + 1'b1;
            end
        end
        if (r_state == ST_MUL) begin
            r_lo <= SW'(i_cfg.min_period) * SW'(r_n);
            r_hi <= SW'(i_cfg.max_period) * SW'(r_n);
        end
        r_rd_vld <= r_slot_vld[r_idx[IW-1:0]];
        if (r_state == ST_OUT && w_out_free) begin
            r_res.busy_res       <= r_busy;
            r_res.done_res       <= r_done;
            r_res.verified       <= r_pass;
            r_res.pulse_edge     <= r_edge;
            r_res.pulse_total    <= r_pc;
            r_res.filtered_level <= r_fo_mag;
            r_res.sunlight_flag  <= ({1'b0, r_x} > {i_cfg.threshold, 1'b0}) && (r_pc < 8'd2);
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fo       <= '0;
            r_fo_mag   <= '0;
            r_prev     <= '0;
            r_seen     <= 1'b0;
            r_lvl      <= 1'b0;
            r_have     <= 1'b0;
            r_last     <= '0;
            r_ptr      <= '0;
            r_slot_vld <= '0;
            r_pc       <= '0;
            r_start    <= '0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_pass     <= 1'b0;
            r_edge     <= 1'b0;
            r_pend     <= 1'b0;
            r_chk      <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_FILT: begin
                    r_edge <= 1'b0;
                    if (r_cmd == CMD_START) begin
                        // Open the window and drop the pulse history
                        r_lvl      <= 1'b0;
                        r_have     <= 1'b0;
                        r_last     <= '0;
                        r_ptr      <= '0;
                        r_slot_vld <= '0;
                        r_pc       <= '0;
                        r_start    <= r_t;
                        r_busy     <= 1'b1;
                        r_done     <= 1'b0;
                        r_pass     <= 1'b0;
                    end else if (r_busy) begin
                        r_seen <= 1'b1;
                        r_prev <= r_x;
                    end
                end
                ST_EDGE: begin
                    r_fo     <= w_fo_new;
                    r_fo_mag <= w_mag;
                    r_lvl    <= w_high;
                    r_edge   <= w_edge;
                    r_pc     <= w_pc_next;
                    r_chk    <= w_go_scan;
                    r_pend   <= 1'b0;
                    if (w_edge) begin
                        r_last <= r_t;
                        r_have <= 1'b1;
                    end
                    if (w_rec) begin
                        r_slot_vld[r_ptr] <= 1'b1;
                        r_ptr <= (r_ptr == IW'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
                    end
                end
                ST_SCAN: begin
                    r_pend <= w_issue;
                end
                ST_DECIDE: begin
                    if (w_ok) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_pass <= 1'b1;
                    end else if (w_elapsed >= i_cfg.window) begin
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                        r_pass <= 1'b0;
                    end
                end
                default: begin
                end
            endcase

            // Hold the result until the receiver takes it
            if (r_state == ST_OUT && w_out_free) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_res       = r_res;

endmodule

>>> sv/pulse_frequency_verifier.sv
// Top level of the pulse frequency verifier: configuration registers, front and back ends.
//
// Input channel: i_in_valid / o_in_stall carry one beat of {func, sample, time_us}.
// func 1 opens a verification window and clears the pulse history; func 0 is a light
// sample that is filtered and checked for edges while the window is open.
// Output channel: o_out_valid / i_out_stall carry one result beat per input beat,
// held stable while the receiver stalls.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// do so only while no item is in flight.
// Sequencing: the back end handles one item at a time. A start item or a sample outside
// the window passes the filter and output states; a sample in the window also passes
// the edge and decide states; one that triggers the period check also the scan and multiply
// states, the scan reading min(pulse_total - 1, INTERVAL_SLOTS) ring slots one per cycle.
// A two-beat queue behind the input lets the front accept while the back is busy.
// A stalled output holds the back end in its output state; the queue then fills and
// o_in_stall rises. Reset clears the queue, the history and the result valid flag and
// loads the configuration defaults; no clearing pass is needed.
module pulse_frequency_verifier #(
    parameter int INTERVAL_SLOTS = pfv_pkg::SLOTS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pfv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pfv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [11:0]                    i_sample,
    input  logic [31:0]                    i_time_us,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic                           o_busy_res,
    output logic                           o_done_res,
    output logic                           o_verified,
    output logic                           o_pulse_edge,
    output logic [7:0]                     o_pulse_total,
    output logic [14:0]                    o_filtered_level,
    output logic                           o_sunlight_flag
);
    import pfv_pkg::*;

    t_cfg  r_cfg;
    logic  w_item_vld;
    t_item w_item;
    logic  w_pop;
    t_res  w_res;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha      <= ALPHA_RST;
            r_cfg.threshold  <= THRESHOLD_RST;
            r_cfg.min_count  <= MIN_CNT_RST;
            r_cfg.min_period <= MIN_PERIOD_RST;
            r_cfg.max_period <= MAX_PERIOD_RST;
            r_cfg.window     <= WINDOW_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ALPHA:      r_cfg.alpha      <= i_cfg_data[7:0];
                CFG_THRESHOLD:  r_cfg.threshold  <= i_cfg_data[11:0];
                CFG_MIN_COUNT:  r_cfg.min_count  <= i_cfg_data[7:0];
                CFG_MIN_PERIOD: r_cfg.min_period <= i_cfg_data[31:0];
                CFG_MAX_PERIOD: r_cfg.max_period <= i_cfg_data[31:0];
                CFG_WINDOW:     r_cfg.window     <= i_cfg_data[31:0];
                default: begin
                end
            endcase
        end
    end

    pfv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_func     (i_func),
        .i_sample   (i_sample),
        .i_time_us  (i_time_us),
        .o_item_vld (w_item_vld),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    pfv_back #(
        .SLOTS (INTERVAL_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_item_vld  (w_item_vld),
        .i_item      (w_item),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_res       (w_res)
    );

    assign o_busy_res       = w_res.busy_res;
    assign o_done_res       = w_res.done_res;
    assign o_verified       = w_res.verified;
    assign o_pulse_edge     = w_res.pulse_edge;
    assign o_pulse_total    = w_res.pulse_total;
    assign o_filtered_level = w_res.filtered_level;
    assign o_sunlight_flag  = w_res.sunlight_flag;

endmodule

>>> sv/pfv_checker.sv
// Port-level checker for the pulse frequency verifier and its bind.
module pfv_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_busy_res,
    input logic        o_done_res,
    input logic        o_verified,
    input logic [7:0]  o_pulse_total,
    input logic        o_sunlight_flag
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_verified)
            && $stable(o_pulse_total) && $stable(o_busy_res))
        else $error("stalled result beat changed");

    // A pass is only reported with a finished verification
    a_pass_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_verified |-> o_done_res && !o_busy_res)
        else $error("verified without done");

    // An open window and a finished verification exclude each other
    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_busy_res && o_done_res))
        else $error("busy and done together");

    // Sunlight is flagged only with fewer than two intervals
    a_sun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sunlight_flag |-> o_pulse_total < 8'd2)
        else $error("sunlight flag with pulses recorded");

    // No result beat straight after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat after reset");

endmodule

bind pulse_frequency_verifier pfv_checker u_pfv_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_busy_res      (o_busy_res),
    .o_done_res      (o_done_res),
    .o_verified      (o_verified),
    .o_pulse_total   (o_pulse_total),
    .o_sunlight_flag (o_sunlight_flag)
);

>>> test/pulse_frequency_verifier_tb.sv
// Self-checking testbench for the pulse frequency verifier: directed and random pulse trains.
`timescale 1ns / 100ps

module pulse_frequency_verifier_tb;
    import pfv_pkg::*;

    localparam int SLOTS = SLOTS_DEF;

    // Predicts every result beat of the block and checks the beats it returns
    class pulse_rate_scoreboard;
        logic [7:0]         alpha;
        logic [11:0]        threshold;
        logic [7:0]         min_count;
        logic [31:0]        min_period;
        logic [31:0]        max_period;
        logic [31:0]        window;
        logic signed [15:0] filt;
        logic [11:0]        prev_raw;
        bit                 seen_first;
        bit                 level_high;
        bit                 have_rise;
        logic [31:0]        last_rise;
        logic [31:0]        intervals [SLOTS];
        int unsigned        slot_ptr;
        logic [7:0]         pulses;
        logic [31:0]        start_stamp;
        bit                 busy;
        bit                 done;
        bit                 passed;
        t_res               expected_q [$];
        int unsigned        errors;
        int unsigned        results;
        int unsigned        rises;
        int unsigned        passes;
        int unsigned        timeouts;
        int unsigned        peak;

        function new();
            alpha      = ALPHA_RST;
            threshold  = THRESHOLD_RST;
            min_count  = MIN_CNT_RST;
            min_period = MIN_PERIOD_RST;
            max_period = MAX_PERIOD_RST;
            window     = WINDOW_RST;
            filt       = '0;
            prev_raw   = '0;
            seen_first = 1'b0;
            clear_history();
            start_stamp = '0;
            busy     = 1'b0;
            done     = 1'b0;
            passed   = 1'b0;
            errors   = 0;
            results  = 0;
            rises    = 0;
            passes   = 0;
            timeouts = 0;
            peak     = 0;
        endfunction

        function void clear_history();
            level_high = 1'b0;
            have_rise  = 1'b0;
            last_rise  = '0;
            foreach (intervals[i]) intervals[i] = '0;
            slot_ptr = 0;
            pulses   = '0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] value);
            case (idx)
                CFG_ALPHA:      alpha      = value[7:0];
                CFG_THRESHOLD:  threshold  = value[11:0];
                CFG_MIN_COUNT:  min_count  = value[7:0];
                CFG_MIN_PERIOD: min_period = value;
                CFG_MAX_PERIOD: max_period = value;
                CFG_WINDOW:     window     = value;
                default: ;
            endcase
        endfunction

        // Magnitude of the filter output, saturated to 15 bits
        function int magnitude(logic signed [15:0] v);
            int vi;
            vi = int'(v);
            if (vi < 0) vi = -vi;
            return (vi > 32767) ? 32767 : vi;
        endfunction

        function void note_item(t_cmd cmd, logic [11:0] raw, logic [31:0] now);
            int          fi;
            int          xi;
            int          pi;
            int          s;
            longint      t;
            longint      m;
            logic [63:0] sum;
            logic [63:0] n;
            logic [31:0] elapsed;
            int unsigned lim;
            bit          high;
            bit          rise;
            bit          in_range;
            t_res        want;
            rise = 1'b0;
            if (cmd == CMD_START) begin
                clear_history();
                start_stamp = now;
                busy   = 1'b1;
                done   = 1'b0;
                passed = 1'b0;
            end else if (busy) begin
                // load the filter from the very first sample
                if (!seen_first) begin
                    prev_raw   = raw;
                    filt       = $signed({4'd0, raw});
                    seen_first = 1'b1;
                end
                // high-pass step: scale by alpha, truncate toward zero, saturate
                fi = int'(filt);
                xi = int'(raw);
                pi = int'(prev_raw);
                s  = fi + xi - pi;
                t  = longint'(alpha) * longint'(s);
                m  = (t < 0) ? -t : t;
                m  = m >> 8;
                if (t < 0)
                    filt = (m > 32768) ? 16'sh8000 : 16'(-m);
                else
                    filt = (m > 32767) ? 16'sh7fff : 16'(m);
                prev_raw = raw;

                // rising crossing of the threshold records an interval
                high = magnitude(filt) > threshold;
                if (high && !level_high) begin
                    rise = 1'b1;
                    rises++;
                    if (have_rise) begin
                        intervals[slot_ptr] = now - last_rise;
                        slot_ptr = (slot_ptr + 1) % SLOTS;
                        if (pulses < 8'd255) pulses++;
                    end
                    last_rise = now;
                    have_rise = 1'b1;
                end
                level_high = high;
                if (pulses > peak) peak = pulses;

                // average of the nonzero intervals against the period window
                in_range = 1'b0;
                if (pulses >= 8'd2) begin
                    lim = pulses - 1;
                    if (lim > SLOTS) lim = SLOTS;
                    sum = '0;
                    n   = '0;
                    for (int i = 0; i < lim; i++) begin
                        if (intervals[i] != 0) begin
                            sum += intervals[i];
                            n++;
                        end
                    end
                    in_range = (n != 0) && (sum >= min_period * n) && (sum <= max_period * n);
                end
                elapsed = now - start_stamp;
                if (pulses >= min_count && in_range) begin
                    busy   = 1'b0;
                    done   = 1'b1;
                    passed = 1'b1;
                    passes++;
                end else if (elapsed >= window) begin
                    busy   = 1'b0;
                    done   = 1'b1;
                    passed = 1'b0;
                    timeouts++;
                end
            end
            want.busy_res       = busy;
            want.done_res       = done;
            want.verified       = passed;
            want.pulse_edge     = rise;
            want.pulse_total    = pulses;
            want.filtered_level = 15'(magnitude(filt));
            want.sunlight_flag  = ({1'b0, raw} > {threshold, 1'b0}) && (pulses < 8'd2);
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                $display("%0t: result beat with nothing pending, got %h", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results++;
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("verified", want.verified, got.verified);
            compare_field("pulse_edge", want.pulse_edge, got.pulse_edge);
            compare_field("pulse_total", want.pulse_total, got.pulse_total);
            compare_field("filtered_level", want.filtered_level, got.filtered_level);
            compare_field("sunlight_flag", want.sunlight_flag, got.sunlight_flag);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_func = 1'b0;
    logic [11:0]           i_sample = '0;
    logic [31:0]           i_time_us = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic                  o_verified;
    logic                  o_pulse_edge;
    logic [7:0]            o_pulse_total;
    logic [14:0]           o_filtered_level;
    logic                  o_sunlight_flag;

    t_res                  out_beat;
    pulse_rate_scoreboard  sb;
    int                    sender_pct = 0;
    int                    stall_pct = 0;
    int unsigned           items_sent = 0;

    pulse_frequency_verifier dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_func           (i_func),
        .i_sample         (i_sample),
        .i_time_us        (i_time_us),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_busy_res       (o_busy_res),
        .o_done_res       (o_done_res),
        .o_verified       (o_verified),
        .o_pulse_edge     (o_pulse_edge),
        .o_pulse_total    (o_pulse_total),
        .o_filtered_level (o_filtered_level),
        .o_sunlight_flag  (o_sunlight_flag)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    assign out_beat = {o_busy_res, o_done_res, o_verified, o_pulse_edge,
                       o_pulse_total, o_filtered_level, o_sunlight_flag};

    // Stall the result channel at random
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(out_beat);
    end

    function void set_idling(int phase);
        case (phase % 4)
            0: begin sender_pct = 0;  stall_pct = 0;  end
            1: begin sender_pct = 82; stall_pct = 0;  end
            2: begin sender_pct = 0;  stall_pct = 82; end
            default: begin sender_pct = 36; stall_pct = 36; end
        endcase
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        sb.set_reg(idx, value);
        @(negedge i_clk);
    endtask

    // Write the whole register set back to back, then drop the enable
    task automatic program_regs(logic [7:0] alpha, logic [11:0] thr, logic [7:0] cnt,
                                logic [31:0] lo, logic [31:0] hi, logic [31:0] win);
        cfg_write(CFG_ALPHA, alpha);
        cfg_write(CFG_THRESHOLD, thr);
        cfg_write(CFG_MIN_COUNT, cnt);
        cfg_write(CFG_MIN_PERIOD, lo);
        cfg_write(CFG_MAX_PERIOD, hi);
        cfg_write(CFG_WINDOW, win);
        i_cfg_we <= 1'b0;
    endtask

    // Present one input beat, hold it until accepted
    task automatic send_item(t_cmd cmd, logic [11:0] raw, logic [31:0] now);
        while ($urandom_range(99) < sender_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= cmd;
        i_sample   <= raw;
        i_time_us  <= now;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_item(cmd, raw, now);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait until every expected result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.expected_q.size() != 0) @(negedge i_clk);
    endtask

    // One verification attempt: random settings, then a pulse train with some noise
    task automatic run_pulse_train();
        logic [7:0]  alpha;
        logic [7:0]  cnt;
        logic [11:0] thr;
        logic [11:0] base;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] win;
        logic [31:0] now;
        logic [31:0] period;
        int unsigned dt;
        int unsigned spacing;
        int unsigned len;
        dt      = $urandom_range(20, 400);
        spacing = $urandom_range(2, 6);
        period  = dt * spacing;
        len     = $urandom_range(12, 40);
        alpha = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                         : 8'($urandom_range(180, 255));
        thr   = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 12'd4095 : 12'd0)
                                         : 12'($urandom_range(50, 1200));
        cnt   = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd1)
                                         : 8'($urandom_range(1, 8));
        case ($urandom_range(9))
            0: begin lo = '0; hi = '1; end
            1: begin lo = '1; hi = '0; end
            2: begin
                lo = period + $urandom_range(8, 60);
                hi = lo + $urandom_range(0, 50);
            end
            default: begin
                lo = period - $urandom_range(0, period / 8);
                hi = period + $urandom_range(0, period / 8) + 3;
            end
        endcase
        case ($urandom_range(7))
            0: win = '0;
            1: win = '1;
            2: win = $urandom_range(1, period * 3);
            default: win = period * (cnt + 4);
        endcase
        program_regs(alpha, thr, cnt, lo, hi, win);

        // open the window, sometimes just short of the timestamp wrap
        now  = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 5000) : $urandom();
        base = $urandom_range(0, 400);
        send_item(CMD_START, 12'($urandom()), now);
        for (int i = 0; i < len; i++) begin
            now += dt + (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
            if ($urandom_range(9) == 0)
                send_item(($urandom_range(2) == 0) ? CMD_START : CMD_SAMPLE,
                          12'($urandom()), $urandom());
            else if (i % spacing == spacing - 1)
                send_item(CMD_SAMPLE, 12'($urandom_range(2000, 4095)), now);
            else
                send_item(CMD_SAMPLE, base + 12'($urandom_range(0, 30)), now);
        end
    endtask

    initial begin
        int unsigned directed_items;
        int          session;
        logic [11:0] level;
        logic [31:0] stamp;
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // samples before any window is open are ignored
        send_item(CMD_SAMPLE, 12'hFFF, 32'h0000_0000);
        send_item(CMD_SAMPLE, 12'h000, 32'hFFFF_FFFF);
        // open a window near the wrap; the first sample ever loads the filter
        send_item(CMD_START, 12'h000, 32'hFFFF_FF00);
        send_item(CMD_SAMPLE, 12'hFFF, 32'hFFFF_FF10);
        send_item(CMD_SAMPLE, 12'h000, 32'hFFFF_FF20);
        send_item(CMD_SAMPLE, 12'hFFF, 32'hFFFF_FF10 + 32'd1000);
        // exactly on the default window: time out, then ignore the next sample
        send_item(CMD_SAMPLE, 12'h000, 32'hFFFF_FF00 + 32'd2000000);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd7);
        drain();

        // one interval exactly on a zero-width period window: too few intervals for a verdict
        program_regs(8'd1, 12'd0, 8'd2, 32'd1000, 32'd1000, '1);
        send_item(CMD_START, 12'h800, 32'd1000);
        send_item(CMD_SAMPLE, 12'h000, 32'd1000);
        send_item(CMD_SAMPLE, 12'h000, 32'd1500);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd2000);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd2500);
        send_item(CMD_SAMPLE, 12'h000, 32'd3000);
        drain();

        // filter off, top threshold, zero window: time out on the first sample
        program_regs(8'd0, 12'd4095, 8'd1, 32'd0, '1, 32'd0);
        send_item(CMD_START, 12'h000, 32'hFFFF_FFFF);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd0);
        drain();

        // edges on one timestamp give zero intervals only: no verdict
        program_regs(8'd1, 12'd0, 8'd2, 32'd0, '1, '1);
        send_item(CMD_START, 12'h000, 32'd50);
        send_item(CMD_SAMPLE, 12'h000, 32'd60);
        send_item(CMD_SAMPLE, 12'h000, 32'd60);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd60);
        send_item(CMD_SAMPLE, 12'hFFF, 32'd60);
        send_item(CMD_SAMPLE, 12'h000, 32'd60);
        directed_items = items_sent;

        // a few random pulse trains, at least one in each of the first three idling phases
        for (session = 0; session < 3 || items_sent - directed_items < 60; session++) begin
            drain();
            set_idling(session);
            run_pulse_train();
        end

        // long train of edges to saturate the pulse count; the check never passes
        drain();
        set_idling(3);
        program_regs(8'd1, 12'd0, 8'd255, '1, 32'd0, '1);
        stamp = $urandom();
        send_item(CMD_START, 12'($urandom()), stamp);
        level = 12'($urandom());
        for (int i = 0; i < 520; i++) begin
            stamp += $urandom_range(1, 100);
            if (i % 2 == 0) level = level + 12'($urandom_range(256, 3839));
            send_item(CMD_SAMPLE, level, stamp);
        end

        // let any stray result beat show up
        drain();
        repeat (40) @(negedge i_clk);

        $display("Run sent %0d beats and checked %0d results across %0d random trains",
                 items_sent, sb.results, session);
        $display("Saw %0d pulse edges, %0d passes, %0d timeouts, pulse count up to %0d",
                 sb.rises, sb.passes, sb.timeouts, sb.peak);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
